// ===== sv/gbd_pkg.sv =====
`timescale 1ns / 1ps
package gbd_pkg;

  localparam int NODES  = 16;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int REQ_W  = 2;
  localparam int NCFG_W = 5;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_NODE_COUNT = '0;
  localparam logic [NCFG_W-1:0] NODE_COUNT_RST = NCFG_W'(16);

  typedef logic [NODES-1:0]  row_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_BFS  = 2'd1,
    REQ_DFS  = 2'd2,
    REQ_RSVD = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WA,
    ST_EDGE_RB,
    ST_EDGE_WB,
    ST_SCAN,
    ST_FETCH,
    ST_LAST,
    ST_BAD
  } st_t;

  typedef struct packed {
    logic  rd;
    logic  wr;
    node_t addr;
    row_t  wdata;
  } adj_cmd_t;

  typedef struct packed {
    logic  rd;
    logic  wr;
    node_t addr;
    node_t wdata;
  } pend_cmd_t;

  function automatic row_t node_bit(node_t n);
    node_bit = row_t'(1) << n;
  endfunction

  // lowest set bit wins
  function automatic node_t lowest_idx(row_t v);
    node_t idx;
    idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = NODE_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic row_t live_mask(cnt_t n);
    row_t m;
    for (int i = 0; i < NODES; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// ===== sv/gbd_if.sv =====
`timescale 1ns / 1ps
interface gbd_req_if;
  logic                        valid;
  logic                        ready;
  logic [gbd_pkg::REQ_W-1:0]   req_type;
  logic [gbd_pkg::NODE_W-1:0]  node_a;
  logic [gbd_pkg::NODE_W-1:0]  node_b;

  modport source (output valid, output req_type, output node_a, output node_b, input ready);
  modport sink   (input valid, input req_type, input node_a, input node_b, output ready);
endinterface

interface gbd_res_if;
  logic                        valid;
  logic                        ready;
  logic [gbd_pkg::NODE_W-1:0]  node;
  logic                        is_last;
  logic                        bad_start;

  modport source (output valid, output node, output is_last, output bad_start, input ready);
  modport sink   (input valid, input node, input is_last, input bad_start, output ready);
endinterface

// ===== sv/gbd_adj_ram.sv =====
`timescale 1ns / 1ps
module gbd_adj_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  gbd_pkg::adj_cmd_t cmd,
  output gbd_pkg::row_t     row
);

  gbd_pkg::row_t              mem_r [gbd_pkg::NODES];
  gbd_pkg::row_t              rdata_r;
  logic [gbd_pkg::NODES-1:0]  vld_r;
  logic                       rvld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem_r[cmd.addr];
    end
  end

  // a row never written since reset reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (cmd.wr) begin
        vld_r[cmd.addr] <= 1'b1;
      end
      if (cmd.rd) begin
        rvld_r <= vld_r[cmd.addr];
      end
    end
  end

  assign row = rvld_r ? rdata_r : '0;

endmodule

// ===== sv/gbd_pend_ram.sv =====
`timescale 1ns / 1ps
module gbd_pend_ram (
  input  logic               clk,
  input  gbd_pkg::pend_cmd_t cmd,
  output gbd_pkg::node_t     rdata
);

  gbd_pkg::node_t mem_r [gbd_pkg::NODES];
  gbd_pkg::node_t rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem_r[cmd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gbd_ctrl.sv =====
`timescale 1ns / 1ps
module gbd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gbd_pkg::REQ_W-1:0]     in_req,
  input  gbd_pkg::node_t                in_a,
  input  gbd_pkg::node_t                in_b,
  input  logic [gbd_pkg::NCFG_W-1:0]    node_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbd_pkg::node_t                out_node,
  output logic                          out_last,
  output logic                          out_bad,
  output gbd_pkg::adj_cmd_t             adj_cmd,
  input  gbd_pkg::row_t                 adj_row,
  output gbd_pkg::pend_cmd_t            pend_cmd,
  input  gbd_pkg::node_t                pend_rdata
);

  gbd_pkg::st_t   state_r, state_nxt;
  logic           dfs_r, dfs_nxt;
  gbd_pkg::node_t a_r, a_nxt;
  gbd_pkg::node_t b_r, b_nxt;
  gbd_pkg::row_t  live_r, live_nxt;
  gbd_pkg::row_t  visited_r, visited_nxt;
  gbd_pkg::node_t held_r, held_nxt;
  gbd_pkg::cnt_t  head_r, head_nxt;
  gbd_pkg::cnt_t  tail_r, tail_nxt;
  logic           out_valid_r, out_valid_nxt;
  gbd_pkg::node_t out_node_r, out_node_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_bad_r, out_bad_nxt;

  gbd_pkg::cnt_t  n_eff;
  gbd_pkg::row_t  cand;
  gbd_pkg::node_t v;
  gbd_pkg::cnt_t  tail_m2;
  logic           out_free;
  logic           a_ok, b_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dfs_r      <= dfs_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    live_r     <= live_nxt;
    visited_r  <= visited_nxt;
    held_r     <= held_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    out_node_r <= out_node_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  always_comb begin
    n_eff = (node_count > gbd_pkg::NCFG_W'(gbd_pkg::NODES)) ? gbd_pkg::CNT_W'(gbd_pkg::NODES)
                                                            : gbd_pkg::CNT_W'(node_count);
    a_ok     = ({1'b0, in_a} < n_eff);
    b_ok     = ({1'b0, in_b} < n_eff);
    cand     = adj_row & live_r & ~visited_r;
    v        = gbd_pkg::lowest_idx(cand);
    tail_m2  = tail_r - gbd_pkg::CNT_W'(2);
    out_free = !out_valid_r || out_ready;

    state_nxt     = state_r;
    dfs_nxt       = dfs_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    live_nxt      = live_r;
    visited_nxt   = visited_r;
    held_nxt      = held_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_node_nxt  = out_node_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    adj_cmd       = '0;
    pend_cmd      = '0;
    in_ready      = 1'b0;

    case (state_r)
      gbd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (gbd_pkg::req_t'(in_req))
            gbd_pkg::REQ_ADD: begin
              if (a_ok && b_ok) begin
                a_nxt        = in_a;
                b_nxt        = in_b;
                adj_cmd.rd   = 1'b1;
                adj_cmd.addr = in_a;
                state_nxt    = gbd_pkg::ST_EDGE_WA;
              end
            end
            gbd_pkg::REQ_BFS, gbd_pkg::REQ_DFS: begin
              dfs_nxt = (gbd_pkg::req_t'(in_req) == gbd_pkg::REQ_DFS);
              if (a_ok) begin
                live_nxt       = gbd_pkg::live_mask(n_eff);
                visited_nxt    = gbd_pkg::node_bit(in_a);
                held_nxt       = in_a;
                pend_cmd.wr    = 1'b1;
                pend_cmd.addr  = '0;
                pend_cmd.wdata = in_a;
                // start row is read right here, so the queue head is past it
                head_nxt       = gbd_pkg::CNT_W'(1);
                tail_nxt       = gbd_pkg::CNT_W'(1);
                adj_cmd.rd     = 1'b1;
                adj_cmd.addr   = in_a;
                state_nxt      = gbd_pkg::ST_SCAN;
              end else begin
                state_nxt = gbd_pkg::ST_BAD;
              end
            end
            default: ;
          endcase
        end
      end

      gbd_pkg::ST_EDGE_WA: begin
        adj_cmd.wr    = 1'b1;
        adj_cmd.addr  = a_r;
        adj_cmd.wdata = adj_row | gbd_pkg::node_bit(b_r);
        state_nxt     = gbd_pkg::ST_EDGE_RB;
      end

      // separate read keeps a self loop correct: row a is already written
      gbd_pkg::ST_EDGE_RB: begin
        adj_cmd.rd   = 1'b1;
        adj_cmd.addr = b_r;
        state_nxt    = gbd_pkg::ST_EDGE_WB;
      end

      gbd_pkg::ST_EDGE_WB: begin
        adj_cmd.wr    = 1'b1;
        adj_cmd.addr  = b_r;
        adj_cmd.wdata = adj_row | gbd_pkg::node_bit(a_r);
        state_nxt     = gbd_pkg::ST_IDLE;
      end

      gbd_pkg::ST_SCAN: begin
        if (cand != '0) begin
          // the held node goes out once a successor proves it is not last
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = held_r;
            out_last_nxt  = 1'b0;
            out_bad_nxt   = 1'b0;
            held_nxt      = v;
            visited_nxt   = visited_r | gbd_pkg::node_bit(v);
            if (tail_r < gbd_pkg::CNT_W'(gbd_pkg::NODES)) begin
              pend_cmd.wr    = 1'b1;
              pend_cmd.addr  = tail_r[gbd_pkg::NODE_W-1:0];
              pend_cmd.wdata = v;
              tail_nxt       = tail_r + gbd_pkg::CNT_W'(1);
              if (dfs_r) begin
                adj_cmd.rd   = 1'b1;
                adj_cmd.addr = v;
              end
            end
          end
        end else if (dfs_r) begin
          tail_nxt = tail_r - gbd_pkg::CNT_W'(1);
          if (tail_r <= gbd_pkg::CNT_W'(1)) begin
            state_nxt = gbd_pkg::ST_LAST;
          end else begin
            pend_cmd.rd   = 1'b1;
            pend_cmd.addr = tail_m2[gbd_pkg::NODE_W-1:0];
            state_nxt     = gbd_pkg::ST_FETCH;
          end
        end else begin
          if (head_r < tail_r) begin
            pend_cmd.rd   = 1'b1;
            pend_cmd.addr = head_r[gbd_pkg::NODE_W-1:0];
            head_nxt      = head_r + gbd_pkg::CNT_W'(1);
            state_nxt     = gbd_pkg::ST_FETCH;
          end else begin
            state_nxt = gbd_pkg::ST_LAST;
          end
        end
      end

      gbd_pkg::ST_FETCH: begin
        adj_cmd.rd   = 1'b1;
        adj_cmd.addr = pend_rdata;
        state_nxt    = gbd_pkg::ST_SCAN;
      end

      gbd_pkg::ST_LAST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = held_r;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b0;
          state_nxt     = gbd_pkg::ST_IDLE;
        end
      end

      gbd_pkg::ST_BAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
          state_nxt     = gbd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gbd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_last  = out_last_r;
  assign out_bad   = out_bad_r;

endmodule

// ===== sv/graph_bfs_dfs_traversal.sv =====
`timescale 1ns / 1ps
// Graph walker over a 16-node undirected adjacency bit matrix.
// in_if carries requests: add edge (node_a, node_b), breadth-first walk or
// depth-first walk from node_a. Add edge gives no result; a walk gives one
// result per reached node, ascending neighbor order, is_last on the final
// one. A start node at or above node_count gives one result with bad_start.
// The user must see that node_count is written over the APB port only
// while the block is idle; the block itself does not enforce it. Add edge
// reads row a, writes it, reads row b and writes it. In a walk each node
// found comes from the candidate search; each node expanded afterwards
// (queue pop or stack backtrack) takes a pending-RAM read followed by the
// adjacency-RAM row read. One request is worked on at a time. The output
// register holds one result, so a new request is accepted while the final
// result of the previous one waits.
// A stalled receiver stalls the walk at the next result.
// Reset clears the matrix through per-row valid bits, sets node_count to
// 16 and drops any result in flight.
module graph_bfs_dfs_traversal (
  input  logic                         clk,
  input  logic                         rst_n,
  gbd_req_if.sink                      in_if,
  gbd_res_if.source                    out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbd_pkg::CFG_AW-1:0]   paddr,
  input  logic [gbd_pkg::CFG_DW-1:0]   pwdata,
  output logic [gbd_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  logic [gbd_pkg::NCFG_W-1:0] node_count_r;
  gbd_pkg::adj_cmd_t          adj_cmd;
  gbd_pkg::row_t              adj_row;
  gbd_pkg::pend_cmd_t         pend_cmd;
  gbd_pkg::node_t             pend_rdata;
  logic                       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[gbd_pkg::CFG_AW-1:2] == gbd_pkg::REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= gbd_pkg::NODE_COUNT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      node_count_r <= pwdata[gbd_pkg::NCFG_W-1:0];
    end
  end

  assign prdata = reg_hit ? gbd_pkg::CFG_DW'(node_count_r) : '0;

  gbd_adj_ram u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (adj_cmd),
    .row   (adj_row)
  );

  gbd_pend_ram u_pend (
    .clk   (clk),
    .cmd   (pend_cmd),
    .rdata (pend_rdata)
  );

  gbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_req     (in_if.req_type),
    .in_a       (in_if.node_a),
    .in_b       (in_if.node_b),
    .node_count (node_count_r),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_node   (out_if.node),
    .out_last   (out_if.is_last),
    .out_bad    (out_if.bad_start),
    .adj_cmd    (adj_cmd),
    .adj_row    (adj_row),
    .pend_cmd   (pend_cmd),
    .pend_rdata (pend_rdata)
  );

endmodule

// ===== sv/gbd_chk.sv =====
`timescale 1ns / 1ps
module gbd_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [gbd_pkg::NODE_W-1:0] out_node,
  input logic                  out_last,
  input logic                  out_bad
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_node) && $stable(out_last) && $stable(out_bad))
    else $error("stalled result changed");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad |-> out_last && (out_node == '0))
    else $error("bad start result malformed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind graph_bfs_dfs_traversal gbd_chk u_gbd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_node  (out_if.node),
  .out_last  (out_if.is_last),
  .out_bad   (out_if.bad_start)
);
